// ===== rtl/bba_pkg.sv =====
// Shared constants for the bitmap block allocator: field widths, request and status codes.
package bba_pkg;

  // Field widths
  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 16;
  localparam int STATUS_W  = 3;
  localparam int IDX_OUT_W = 7;
  localparam int BB_W      = SIZE_W + 1;

  // Occupancy map word geometry
  localparam int WORD_W = 32;
  localparam int WBIT_W = 5;

  // Request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ALLOC   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FREED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADSIZE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 3'd4;

endpackage

// ===== rtl/bba_map_mem.sv =====
// Occupancy map storage: one write port, one read port with registered read data.
module bba_map_mem import bba_pkg::*; #(
  parameter int DEPTH  = 4,
  parameter int ADDR_W = 2
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] map_mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      map_mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= map_mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bba_div.sv =====
// Offset to block index by reciprocal multiplication and one correction step, with in-block offset.
module bba_div #(
  parameter int IDX_W       = 7,
  parameter int OFF_W       = 13,
  parameter int BLOCK_BYTES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [OFF_W-1:0] dividend_i,
  output logic             done_o,
  output logic [IDX_W-1:0] quot_o,
  output logic [OFF_W-1:0] rem_o
);

  // floor(2^OFF_W / BLOCK_BYTES): the estimate is the true quotient or one below it
  localparam int     RECIP_W = OFF_W + 1;
  localparam int     MUL_W   = OFF_W + RECIP_W;
  localparam int     BACK_W  = IDX_W + OFF_W;
  localparam longint RECIP_L = (longint'(1) << OFF_W) / longint'(BLOCK_BYTES);
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_L);
  localparam logic [OFF_W-1:0]   DIVISOR = OFF_W'(BLOCK_BYTES);

  logic [3:0]        step_q;
  logic              done_q;
  logic [OFF_W-1:0]  num_q;
  logic [IDX_W-1:0]  est_q;
  logic [OFF_W-1:0]  back_q;
  logic [IDX_W-1:0]  quot_q;
  logic [OFF_W-1:0]  rem_q;
  logic [MUL_W-1:0]  recip_prod;
  logic [BACK_W-1:0] back_prod;

  assign recip_prod = MUL_W'(num_q) * MUL_W'(RECIP);
  assign back_prod  = BACK_W'(est_q) * BACK_W'(DIVISOR);

  // Step control: one-hot walk through estimate, back-multiply, remainder, fix-up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      step_q <= 4'b0001;
      done_q <= 1'b0;
    end else begin
      step_q <= {step_q[2:0], 1'b0};
      if (step_q[3]) begin
        done_q <= 1'b1;
      end
    end
  end

  // Datapath, one multiply or subtract per step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
    end
    if (step_q[0]) begin
      est_q <= recip_prod[OFF_W +: IDX_W];
    end
    if (step_q[1]) begin
      back_q <= OFF_W'(back_prod);
    end
    if (step_q[2]) begin
      quot_q <= est_q;
      rem_q  <= num_q - back_q;
    end
    // estimate one short: remainder is a full block too large
    if (step_q[3] && rem_q >= DIVISOR) begin
      quot_q <= IDX_W'(quot_q + 1'b1);
      rem_q  <= rem_q - DIVISOR;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/bitmap_block_allocator.sv =====
// Allocate scans map words to the first with a clear bit, sets it and forms the address (multiply,
// add), or scans every word if the pool is full; free runs four divider steps, map read, write-back;
// bad size or outside pool go straight to the result. One request at a time; the next is taken the
// cycle after the result moves to the output register. After reset a clearing pass writes NUM_WORDS
// map words (one per cycle) with in_stall_o high; configuration writes are taken at any time.
module bitmap_block_allocator import bba_pkg::*; #(
  parameter int NUM_BLOCKS  = 128,
  parameter int BLOCK_BYTES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [SIZE_W-1:0]    req_size_i,
  input  logic [ADDR_W-1:0]    free_addr_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [ADDR_W-1:0]    block_addr_o,
  output logic [IDX_OUT_W-1:0] blk_idx_o
);

  localparam int NUM_WORDS  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int POOL_BYTES = NUM_BLOCKS * BLOCK_BYTES;
  localparam int OFF_W      = $clog2(POOL_BYTES);
  localparam int PROD_W     = IDX_W + BB_W;
  localparam int SPLIT_W    = WADDR_W + WBIT_W;
  localparam int LAST_BITS  = NUM_BLOCKS - WORD_W * (NUM_WORDS - 1);
  localparam logic [WORD_W-1:0]  PAD_MASK   = ~({WORD_W{1'b1}} >> (WORD_W - LAST_BITS));
  localparam logic [WADDR_W-1:0] LAST_WORD  = WADDR_W'(NUM_WORDS - 1);
  localparam logic [ADDR_W-1:0]  POOL_LIMIT = ADDR_W'(POOL_BYTES);
  localparam logic [BB_W-1:0]    BLOCK_SIZE = BB_W'(BLOCK_BYTES);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_ADD   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_FWR   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  // Lowest clear bit of a map word
  function automatic logic [WBIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
    logic [WBIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = WBIT_W'(i);
      end
    end
    return pos;
  endfunction

  state_e                 state_q, state_d;
  logic [ADDR_W-1:0]      pool_base_q;
  logic [WADDR_W-1:0]     word_q;
  logic                   out_valid_q;
  logic [ADDR_W-1:0]      addr_q;
  logic [IDX_W-1:0]       idx_q;
  logic [PROD_W-1:0]      prod_q;
  logic [STATUS_W-1:0]    res_status_q;
  logic [ADDR_W-1:0]      res_addr_q;
  logic [IDX_OUT_W-1:0]   res_idx_q;
  logic [STATUS_W-1:0]    out_status_q;
  logic [ADDR_W-1:0]      out_addr_q;
  logic [IDX_OUT_W-1:0]   out_idx_q;

  logic                   in_acc;
  logic                   out_load;
  logic [ADDR_W-1:0]      offset;
  logic                   outside;
  logic                   bad_size;
  logic [WORD_W-1:0]      rdata;
  logic [WORD_W-1:0]      scan_word;
  logic                   scan_hit;
  logic [WBIT_W-1:0]      scan_bit;
  logic [SPLIT_W-1:0]     scan_split;
  logic [SPLIT_W-1:0]     idx_split;
  logic [SPLIT_W-1:0]     quot_split;

  logic                   mem_we;
  logic [WADDR_W-1:0]     mem_waddr;
  logic [WORD_W-1:0]      mem_wdata;
  logic                   mem_re;
  logic [WADDR_W-1:0]     mem_raddr;

  logic                   div_start;
  logic                   div_done;
  logic [IDX_W-1:0]       div_quot;
  logic [OFF_W-1:0]       div_rem;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // Request checks
  assign offset   = free_addr_i - pool_base_q;
  assign outside  = (offset >= POOL_LIMIT);
  assign bad_size = (req_size_i == '0) || ({1'b0, req_size_i} > BLOCK_SIZE);

  // Scan of the word just read; unused tail bits count as taken
  assign scan_word  = rdata | ((word_q == LAST_WORD) ? PAD_MASK : '0);
  assign scan_hit   = ~&scan_word;
  assign scan_bit   = first_zero(scan_word);
  assign scan_split = {word_q, scan_bit};
  assign idx_split  = SPLIT_W'(idx_q);
  assign quot_split = SPLIT_W'(div_quot);

  // Sequencer and map port control
  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = word_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    div_start = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (word_q == LAST_WORD) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (req_type_i == REQ_FREE) begin
            if (outside) begin
              state_d = S_OUT;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end else if (bad_size) begin
            state_d = S_OUT;
          end else begin
            mem_re  = 1'b1;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          mem_we    = 1'b1;
          mem_wdata = rdata | (WORD_W'(1) << scan_bit);
          state_d   = S_MUL;
        end else if (word_q == LAST_WORD) begin
          state_d = S_OUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = WADDR_W'(word_q + 1'b1);
        end
      end
      S_MUL: begin
        state_d = S_ADD;
      end
      S_ADD: begin
        state_d = S_OUT;
      end
      S_DIV: begin
        if (div_done) begin
          mem_re    = 1'b1;
          mem_raddr = quot_split[SPLIT_W-1:WBIT_W];
          state_d   = S_FWR;
        end
      end
      S_FWR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_split[SPLIT_W-1:WBIT_W];
        mem_wdata = rdata & ~(WORD_W'(1) << idx_split[WBIT_W-1:0]);
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      word_q      <= '0;
      out_valid_q <= 1'b0;
      pool_base_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pool_base_q <= cfg_data_i;
      end
      if (state_q == S_CLEAR) begin
        word_q <= WADDR_W'(word_q + 1'b1);
      end else if (in_acc) begin
        word_q <= '0;
      end else if (state_q == S_SCAN && !scan_hit && word_q != LAST_WORD) begin
        word_q <= WADDR_W'(word_q + 1'b1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          addr_q       <= free_addr_i;
          res_addr_q   <= '0;
          res_idx_q    <= '0;
          res_status_q <= (req_type_i == REQ_FREE) ? ST_OUTSIDE : ST_BADSIZE;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          idx_q <= IDX_W'(scan_split);
        end else begin
          res_status_q <= ST_FULL;
        end
      end
      S_MUL: begin
        prod_q <= PROD_W'(idx_q) * PROD_W'(BLOCK_SIZE);
      end
      S_ADD: begin
        res_addr_q   <= pool_base_q + ADDR_W'(prod_q);
        res_idx_q    <= IDX_OUT_W'(idx_q);
        res_status_q <= ST_ALLOC;
      end
      S_DIV: begin
        if (div_done) begin
          idx_q      <= div_quot;
          res_addr_q <= addr_q - ADDR_W'(div_rem);
        end
      end
      S_FWR: begin
        res_idx_q    <= IDX_OUT_W'(idx_q);
        res_status_q <= ST_FREED;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_idx_q    <= res_idx_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign block_addr_o = out_addr_q;
  assign blk_idx_o    = out_idx_q;

  // Occupancy map
  bba_map_mem #(
    .DEPTH  (NUM_WORDS),
    .ADDR_W (WADDR_W)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  // Offset to block index
  bba_div #(
    .IDX_W       (IDX_W),
    .OFF_W       (OFF_W),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (OFF_W'(offset)),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

endmodule

// ===== rtl/bba_checker.sv =====
// Port-level checks for the bitmap block allocator, bound to the top level.
module bba_checker import bba_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [STATUS_W-1:0]  status_o,
  input logic [ADDR_W-1:0]    block_addr_o,
  input logic [IDX_OUT_W-1:0] blk_idx_o
);

  // Failed requests report no block
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_BADSIZE || status_o == ST_FULL || status_o == ST_OUTSIDE)
    |-> block_addr_o == '0 && blk_idx_o == '0)
    else $error("failed request reports a block");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(block_addr_o) && $stable(blk_idx_o))
    else $error("stalled result beat changed");

  // One request in flight: an accepted beat closes the input
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in flight");

  // A fresh result only follows busy time
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in progress");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
